// ===== rtl/jaes_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON array element splitter package
// Phase codes, character codes and the blank test shared by the splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package jaes_pkg;

   // Parser phase: looking for the opening bracket, inside the array, or
   // finished with the array and waiting for the end of the message.
   typedef enum logic [1:0] {
      PH_SEEK   = 2'd0,
      PH_ARRAY  = 2'd1,
      PH_CLOSED = 2'd2
   } phase_type;

   localparam logic [7:0] CH_LBRACK    = 8'h5B;  // [
   localparam logic [7:0] CH_RBRACK    = 8'h5D;  // ]
   localparam logic [7:0] CH_LBRACE    = 8'h7B;  // {
   localparam logic [7:0] CH_RBRACE    = 8'h7D;  // }
   localparam logic [7:0] CH_COMMA     = 8'h2C;  // ,
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;  // backslash
   localparam logic [7:0] CH_QUOTE     = 8'h22;  // double quote
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LF        = 8'h0A;

   // Whitespace as JSON defines it.
   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/json_array_element_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// JSON array element splitter
// Splits the top-level JSON array of a byte stream into element offsets and
// lengths, one message byte per word.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------------
//  req     | in        | req_valid / req_ready | char_byte, end_of_message
//  rsp     | out       | rsp_valid / rsp_ready | elem_start, elem_length,
//          |           |                       | has_element, array_closed,
//          |           |                       | depth_overflow, message_done
//
// A byte is accepted into the input register; when the output register is free,
// the parser state advances and any result is loaded into the output register.
// Bytes are taken at one byte a cycle while no result waits.
// A result that waits stalls the input register, and req_ready falls once that
// register also holds a byte. Reset is synchronous and re-arms the parser to
// seek an opening bracket at offset zero; the final byte of a message does too.
// ----------------------------------------------------------------------------
`default_nettype none

module json_array_element_splitter_unit #(
   parameter int MAX_NEST    = 255,
   parameter int OFFSET_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_byte,
   input  wire logic        req_end_of_message,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_elem_start,
   output logic [15:0]      rsp_elem_length,
   output logic             rsp_has_element,
   output logic             rsp_array_closed,
   output logic             rsp_depth_overflow,
   output logic             rsp_message_done
);

   // Nesting counter is sized so that it can hold the bound itself.
   localparam int NEST_BITS = $clog2(MAX_NEST + 1);
   // Wide enough to compare any length against the 16-bit result ceiling.
   localparam int WIDE_BITS = 33;

   // ---------------------------------------------------------------------
   // Input register stage.
   // ---------------------------------------------------------------------
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       s1_eom_ff;
   logic       s1_fire;
   logic       out_free;

   // ---------------------------------------------------------------------
   // Parser state.
   // ---------------------------------------------------------------------
   jaes_pkg::phase_type    phase_ff, phase_in;
   logic                   in_text_ff, in_text_in;
   logic                   escape_ff, escape_in;
   logic [NEST_BITS-1:0]   nest_ff, nest_in;
   logic                   start_valid_ff, start_valid_in;
   logic [OFFSET_BITS-1:0] start_off_ff, start_off_in;
   logic [OFFSET_BITS-1:0] solid_off_ff, solid_off_in;
   logic [OFFSET_BITS-1:0] byte_off_ff, byte_off_in;
   logic                   overflow_ff, overflow_in;

   // ---------------------------------------------------------------------
   // Output register.
   // ---------------------------------------------------------------------
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_start_ff, rsp_len_ff;
   logic        rsp_has_ff, rsp_closed_ff, rsp_ovf_ff, rsp_done_ff;

   // Per-byte decode results.
   logic                   emit, ends, solid, closed, has;
   logic [15:0]            e_start, e_len;
   logic [OFFSET_BITS:0]   len_full;
   logic [WIDE_BITS-1:0]   len_wide;
   logic                   blank;
   // Overflow flag as it stands after this byte, before any re-arm.
   logic                   ovf_step;

   // The output register can take a new result when it is empty or is
   // handing its current one over in this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;

   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 :
                        (s1_fire ? 1'b0 : s1_valid_ff);

   assign blank = jaes_pkg::is_blank(s1_char_ff);

   // Next parser state and result for the byte in the input register.
   always_comb begin
      phase_in       = phase_ff;
      in_text_in     = in_text_ff;
      escape_in      = escape_ff;
      nest_in        = nest_ff;
      start_valid_in = start_valid_ff;
      start_off_in   = start_off_ff;
      solid_off_in   = solid_off_ff;
      byte_off_in    = byte_off_ff;
      overflow_in    = overflow_ff;
      solid          = 1'b0;
      ends           = 1'b0;
      closed         = 1'b0;
      has            = 1'b0;
      e_start        = '0;
      e_len          = '0;
      len_full       = '0;
      len_wide       = '0;

      unique case (phase_ff)
         jaes_pkg::PH_SEEK: begin
            if (s1_char_ff == jaes_pkg::CH_LBRACK) begin
               phase_in       = jaes_pkg::PH_ARRAY;
               in_text_in     = 1'b0;
               escape_in      = 1'b0;
               nest_in        = '0;
               start_valid_in = 1'b0;
            end
         end
         jaes_pkg::PH_ARRAY: begin
            if (escape_ff) begin
               escape_in = 1'b0;
               solid     = 1'b1;
            end else if (in_text_ff) begin
               if (s1_char_ff == jaes_pkg::CH_BACKSLASH) begin
                  escape_in = 1'b1;
               end else if (s1_char_ff == jaes_pkg::CH_QUOTE) begin
                  in_text_in = 1'b0;
               end
               solid = 1'b1;
            end else if (s1_char_ff == jaes_pkg::CH_QUOTE) begin
               if (!start_valid_ff) begin
                  start_valid_in = 1'b1;
                  start_off_in   = byte_off_ff;
               end
               in_text_in = 1'b1;
               solid      = 1'b1;
            end else if (s1_char_ff == jaes_pkg::CH_LBRACK ||
                         s1_char_ff == jaes_pkg::CH_LBRACE) begin
               if (nest_ff == '0 && !start_valid_ff) begin
                  start_valid_in = 1'b1;
                  start_off_in   = byte_off_ff;
               end
               // Nesting saturates at the bound and leaves a sticky flag.
               if (nest_ff >= NEST_BITS'(MAX_NEST)) begin
                  overflow_in = 1'b1;
               end else begin
                  nest_in = nest_ff + NEST_BITS'(1);
               end
               solid = 1'b1;
            end else if (s1_char_ff == jaes_pkg::CH_RBRACK ||
                         s1_char_ff == jaes_pkg::CH_RBRACE) begin
               if (nest_ff == '0) begin
                  ends     = 1'b1;
                  closed   = 1'b1;
                  phase_in = jaes_pkg::PH_CLOSED;
               end else begin
                  nest_in = nest_ff - NEST_BITS'(1);
                  solid   = 1'b1;
               end
            end else if (nest_ff != '0) begin
               solid = 1'b1;
            end else if (s1_char_ff == jaes_pkg::CH_COMMA) begin
               ends = 1'b1;
            end else if (!blank) begin
               if (!start_valid_ff) begin
                  start_valid_in = 1'b1;
                  start_off_in   = byte_off_ff;
               end
               solid = 1'b1;
            end

            // Remember the last non-blank byte so trailing blanks are trimmed.
            if (solid && start_valid_in && !blank) begin
               solid_off_in = byte_off_ff;
            end

            if (ends) begin
               if (start_valid_in) begin
                  len_full = {1'b0, solid_off_in} - {1'b0, start_off_in} +
                             (OFFSET_BITS+1)'(1);
                  if (solid_off_in < start_off_in) begin
                     len_full = '0;
                  end
                  len_wide = WIDE_BITS'(len_full);
                  e_len    = (len_wide > WIDE_BITS'(16'hFFFF)) ? 16'hFFFF
                                                               : 16'(len_full);
                  e_start  = 16'(start_off_in);
                  has      = 1'b1;
               end
               start_valid_in = 1'b0;
            end
         end
         jaes_pkg::PH_CLOSED: begin
            // Bytes after the close are ignored until the end of the message.
         end
         default: begin
            phase_in = jaes_pkg::PH_SEEK;
         end
      endcase

      emit     = ends || s1_eom_ff;
      ovf_step = overflow_in;

      // The final byte re-arms everything; otherwise the offset counts up and
      // sticks at its ceiling.
      if (s1_eom_ff) begin
         phase_in       = jaes_pkg::PH_SEEK;
         in_text_in     = 1'b0;
         escape_in      = 1'b0;
         nest_in        = '0;
         start_valid_in = 1'b0;
         start_off_in   = '0;
         solid_off_in   = '0;
         byte_off_in    = '0;
         overflow_in    = 1'b0;
      end else if (!(&byte_off_ff)) begin
         byte_off_in = byte_off_ff + OFFSET_BITS'(1);
      end
   end

   assign rsp_valid_in = (s1_fire && emit) ? 1'b1 :
                         (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Handshake and parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= jaes_pkg::PH_SEEK;
         in_text_ff     <= 1'b0;
         escape_ff      <= 1'b0;
         nest_ff        <= '0;
         start_valid_ff <= 1'b0;
         start_off_ff   <= '0;
         solid_off_ff   <= '0;
         byte_off_ff    <= '0;
         overflow_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            phase_ff       <= phase_in;
            in_text_ff     <= in_text_in;
            escape_ff      <= escape_in;
            nest_ff        <= nest_in;
            start_valid_ff <= start_valid_in;
            start_off_ff   <= start_off_in;
            solid_off_ff   <= solid_off_in;
            byte_off_ff    <= byte_off_in;
            overflow_ff    <= overflow_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_char_ff <= req_char_byte;
         s1_eom_ff  <= req_end_of_message;
      end
      if (s1_fire && emit) begin
         rsp_start_ff  <= e_start;
         rsp_len_ff    <= e_len;
         rsp_has_ff    <= has;
         rsp_closed_ff <= closed;
         rsp_ovf_ff    <= ovf_step;
         rsp_done_ff   <= s1_eom_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_elem_start     = rsp_start_ff;
   assign rsp_elem_length    = rsp_len_ff;
   assign rsp_has_element    = rsp_has_ff;
   assign rsp_array_closed   = rsp_closed_ff;
   assign rsp_depth_overflow = rsp_ovf_ff;
   assign rsp_message_done   = rsp_done_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // A reported element always holds at least one byte.
   a_elem_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_element |-> rsp_elem_length != 16'd0)
      else $error("element reported with zero length");

   // Without an element the offset and length fields read as zero.
   a_no_elem_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_element |->
         rsp_elem_start == 16'd0 && rsp_elem_length == 16'd0)
      else $error("stray element fields without an element");

   // While searching for the opening bracket no nesting or string is open.
   a_seek_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == jaes_pkg::PH_SEEK |->
         nest_ff == '0 && !in_text_ff && !escape_ff && !start_valid_ff)
      else $error("parser state left over while seeking the array");

   // The nesting counter never passes its bound.
   a_nest_bound: assert property (@(posedge clock) disable iff (reset)
      nest_ff <= NEST_BITS'(MAX_NEST))
      else $error("nesting counter beyond bound");

   // The byte after a final byte is parsed from offset zero.
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_eom_ff |=> byte_off_ff == '0 && phase_ff == jaes_pkg::PH_SEEK)
      else $error("parser not re-armed after end of message");

endmodule

`default_nettype wire

// ===== bench/tb_json_array_element_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// Testbench for the JSON array element splitter
// Streams messages into the splitter one byte per word and predicts, byte by
// byte, which element reports it must give. Every report that comes out is
// compared field by field with the oldest prediction. Directed messages cover
// trimming, empty elements, escapes, the various ways an array ends and depth
// saturation. Random messages follow, mostly well formed arrays with random
// content, plus noise and cut-off messages.
// ----------------------------------------------------------------------------

module tb_json_array_element_splitter_unit;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 12;
   // Nesting bound given to the block and mirrored by the predictor.
   localparam int DEPTH_LIMIT  = 255;
   localparam int RANDOM_ITEMS = 80;
   // Idle odds on each side, in percent.
   localparam int IDLE_PERCENT = 21;
   // Long receiver hold-off that forces the block to stall its input.
   localparam int STALL_CYCLES = 300;
   // Settling margin after the last report has come.
   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_CYCLES = 100000;

   // One element report as the block presents it.
   typedef struct packed {
      logic [15:0] elem_start;
      logic [15:0] elem_length;
      logic        has_element;
      logic        array_closed;
      logic        depth_overflow;
      logic        message_done;
   } split_report_type;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_byte      = 8'h00;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready          = 1'b0;
   logic [15:0] rsp_elem_start;
   logic [15:0] rsp_elem_length;
   logic        rsp_has_element;
   logic        rsp_array_closed;
   logic        rsp_depth_overflow;
   logic        rsp_message_done;

   // Reports the predictor has worked out and the block still owes.
   split_report_type expected_reports[$];
   // Message under construction; send_message streams it out.
   logic [7:0]       msg_bytes[$];

   int unsigned mismatches    = 0;
   int unsigned bytes_sent    = 0;
   // While set, neither side idles.
   logic        steady        = 1'b0;
   // Set by a test to make the receiver start its long hold-off.
   logic        stall_request = 1'b0;

   // Predictor state: a private copy of the parser state of the block.
   jaes_pkg::phase_type cur_phase;
   logic                in_string;
   logic                escape_next;
   int                  depth;
   logic                elem_open;
   logic [15:0]         elem_first;
   logic [15:0]         last_content;
   logic [15:0]         cur_offset;
   logic                overflowed;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   json_array_element_splitter_unit #(
      .MAX_NEST    (DEPTH_LIMIT),
      .OFFSET_BITS (16)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_byte      (req_char_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_elem_start     (rsp_elem_start),
      .rsp_elem_length    (rsp_elem_length),
      .rsp_has_element    (rsp_has_element),
      .rsp_array_closed   (rsp_array_closed),
      .rsp_depth_overflow (rsp_depth_overflow),
      .rsp_message_done   (rsp_message_done)
   );

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Returns the parser to the state of looking for an opening bracket at
   // offset zero. This happens at reset and after every final byte.
   function automatic void rearm_splitter();
      cur_phase    = jaes_pkg::PH_SEEK;
      in_string    = 1'b0;
      escape_next  = 1'b0;
      depth        = 0;
      elem_open    = 1'b0;
      elem_first   = 16'd0;
      last_content = 16'd0;
      cur_offset   = 16'd0;
      overflowed   = 1'b0;
   endfunction

   // Advances the parser by one accepted byte and queues the report that the
   // byte causes, if any.
   function automatic void predict_split_report(input logic [7:0] c, input logic eom);
      logic             blank;
      logic             solid;
      logic             ends;
      logic             emit;
      logic [15:0]      pos;
      int               span;
      split_report_type rep;
      blank = jaes_pkg::is_blank(c);
      solid = 1'b0;
      ends  = 1'b0;
      emit  = 1'b0;
      pos   = cur_offset;
      rep   = '0;
      case (cur_phase)
         jaes_pkg::PH_SEEK: begin
            if (c == jaes_pkg::CH_LBRACK) begin
               cur_phase   = jaes_pkg::PH_ARRAY;
               in_string   = 1'b0;
               escape_next = 1'b0;
               depth       = 0;
               elem_open   = 1'b0;
            end
         end
         jaes_pkg::PH_ARRAY: begin
            if (escape_next) begin
               // The byte after a backslash is taken as content, whatever it is.
               escape_next = 1'b0;
               solid       = 1'b1;
            end else if (in_string) begin
               if (c == jaes_pkg::CH_BACKSLASH) begin
                  escape_next = 1'b1;
               end else if (c == jaes_pkg::CH_QUOTE) begin
                  in_string = 1'b0;
               end
               solid = 1'b1;
            end else if (c == jaes_pkg::CH_QUOTE) begin
               if (!elem_open) begin
                  elem_open  = 1'b1;
                  elem_first = pos;
               end
               in_string = 1'b1;
               solid     = 1'b1;
            end else if (c == jaes_pkg::CH_LBRACK || c == jaes_pkg::CH_LBRACE) begin
               if (depth == 0 && !elem_open) begin
                  elem_open  = 1'b1;
                  elem_first = pos;
               end
               // The level saturates at the bound and the overflow sticks.
               if (depth >= DEPTH_LIMIT) begin
                  overflowed = 1'b1;
               end else begin
                  depth++;
               end
               solid = 1'b1;
            end else if (c == jaes_pkg::CH_RBRACK || c == jaes_pkg::CH_RBRACE) begin
               if (depth == 0) begin
                  ends              = 1'b1;
                  rep.array_closed  = 1'b1;
                  cur_phase         = jaes_pkg::PH_CLOSED;
               end else begin
                  depth--;
                  solid = 1'b1;
               end
            end else if (depth > 0) begin
               solid = 1'b1;
            end else if (c == jaes_pkg::CH_COMMA) begin
               ends = 1'b1;
            end else if (!blank) begin
               if (!elem_open) begin
                  elem_open  = 1'b1;
                  elem_first = pos;
               end
               solid = 1'b1;
            end

            if (solid && elem_open && !blank) begin
               last_content = pos;
            end

            if (ends) begin
               emit = 1'b1;
               if (elem_open) begin
                  span = int'(last_content) - int'(elem_first) + 1;
                  if (span < 0) begin
                     span = 0;
                  end
                  if (span > 65535) begin
                     span = 65535;
                  end
                  rep.has_element = 1'b1;
                  rep.elem_start  = elem_first;
                  rep.elem_length = 16'(span);
               end
               elem_open = 1'b0;
            end
         end
         default: begin
            // After the close every byte up to the final one is ignored.
         end
      endcase

      if (eom) begin
         emit = 1'b1;
      end
      if (emit) begin
         rep.depth_overflow = overflowed;
         rep.message_done   = eom;
         expected_reports.insert(expected_reports.size(), rep);
      end

      if (eom) begin
         rearm_splitter();
      end else if (cur_offset != 16'hFFFF) begin
         cur_offset++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------

   // Offers one byte and returns in the time step of the edge that accepts
   // it. Valid stays high on return, so back-to-back words need no gap.
   task automatic send_byte(input logic [7:0] c, input logic eom);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_char_byte      <= c;
      req_end_of_message <= eom;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      bytes_sent++;
      predict_split_report(c, eom);
   endtask

   // Streams the message under construction, flagging its last byte.
   task automatic send_message();
      int n;
      n = msg_bytes.size();
      for (int i = 0; i < n; i++) begin
         send_byte(msg_bytes[i], i == n - 1);
      end
      msg_bytes.delete();
   endtask

   // Appends one byte to the message under construction.
   function automatic void add_byte(input logic [7:0] b);
      msg_bytes.insert(msg_bytes.size(), b);
   endfunction

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i]);
      end
   endtask

   // Stops offering words and waits until every predicted report has come,
   // then lets the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Random message construction
   // ------------------------------------------------------------------------

   function automatic logic [7:0] random_blank();
      case ($urandom_range(3))
         0:       return jaes_pkg::CH_SPACE;
         1:       return jaes_pkg::CH_TAB;
         2:       return jaes_pkg::CH_CR;
         default: return jaes_pkg::CH_LF;
      endcase
   endfunction

   // A printable byte with no structural meaning to the parser.
   function automatic logic [7:0] word_char();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(33, 126));
      end while (b == jaes_pkg::CH_LBRACK || b == jaes_pkg::CH_RBRACK ||
                 b == jaes_pkg::CH_LBRACE || b == jaes_pkg::CH_RBRACE ||
                 b == jaes_pkg::CH_COMMA || b == jaes_pkg::CH_QUOTE ||
                 b == jaes_pkg::CH_BACKSLASH);
      return b;
   endfunction

   task automatic add_blanks();
      repeat ($urandom_range(0, 2)) add_byte(random_blank());
   endtask

   // Appends one value: nothing, a bare word, a string with arbitrary bytes
   // and escapes, or a nested array or object holding further values.
   task automatic add_value(input int lvl);
      int         kind;
      int         n;
      logic [7:0] b;
      kind = $urandom_range(lvl < 3 ? 4 : 2);
      n    = $urandom_range(0, 6);
      case (kind)
         0: begin
            // An empty element; the report for it carries no element.
         end
         1: begin
            for (int i = 0; i <= n; i++) begin
               add_byte(word_char());
               if ($urandom_range(9) == 0) begin
                  add_byte(random_blank());
               end
            end
         end
         2: begin
            add_byte(jaes_pkg::CH_QUOTE);
            for (int i = 0; i < n; i++) begin
               b = 8'($urandom_range(255));
               if (b == jaes_pkg::CH_QUOTE || b == jaes_pkg::CH_BACKSLASH ||
                   $urandom_range(7) == 0) begin
                  add_byte(jaes_pkg::CH_BACKSLASH);
               end
               add_byte(b);
            end
            add_byte(jaes_pkg::CH_QUOTE);
         end
         default: begin
            add_byte($urandom_range(1) ? jaes_pkg::CH_LBRACK : jaes_pkg::CH_LBRACE);
            for (int i = 0; i < n / 2; i++) begin
               if (i > 0) begin
                  add_byte(jaes_pkg::CH_COMMA);
               end
               add_blanks();
               add_value(lvl + 1);
            end
            add_byte($urandom_range(1) ? jaes_pkg::CH_RBRACK : jaes_pkg::CH_RBRACE);
         end
      endcase
   endtask

   // Most messages are well formed arrays with random content. A tenth are
   // plain noise, and about one in eight is cut off at a random point.
   task automatic build_random_message();
      int kind;
      int n_elems;
      int ending;
      int cut;
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(255)));
         add_byte(jaes_pkg::CH_LBRACK);
         n_elems = $urandom_range(0, 5);
         for (int i = 0; i < n_elems; i++) begin
            if (i > 0) begin
               add_byte(jaes_pkg::CH_COMMA);
            end
            add_blanks();
            add_value(0);
            add_blanks();
         end
         ending = $urandom_range(9);
         if (ending == 1) begin
            add_byte(jaes_pkg::CH_COMMA);
         end else if (ending != 0) begin
            add_byte(ending == 2 ? jaes_pkg::CH_RBRACE : jaes_pkg::CH_RBRACK);
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(255)));
         end
         if (kind < 22) begin
            cut = $urandom_range(1, msg_bytes.size());
            msg_bytes = msg_bytes[0:cut-1];
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Short hand-made messages: junk before the bracket, trailing blanks that
   // are trimmed, an empty element, an escaped quote and a bracket inside a
   // string, bytes after the close, both extreme byte values, a comma on the
   // final byte, an array that never closes and a close by brace on the
   // final byte.
   task automatic test_directed_forms();
      add_byte(8'h00);
      append_text("a[ 1 , ,\"\\\"]\" ]");
      add_byte(8'hFF);
      send_message();

      add_byte(jaes_pkg::CH_LBRACK);
      add_byte(8'hFF);
      add_byte(jaes_pkg::CH_RBRACK);
      send_message();

      append_text("[[5],");
      send_message();
      append_text("[\t{}");
      send_message();
      append_text("[}");
      send_message();
      wait_idle();
   endtask

   // Nests well past the bound so the level saturates and the overflow flag
   // is raised; the closings then pair up with the saturated count. The next
   // message must start with the flag clear again. Neither side idles here,
   // which gives the run its long stretch at full rate.
   task automatic test_depth_overflow();
      steady = 1'b1;
      add_byte(jaes_pkg::CH_LBRACK);
      for (int i = 0; i < DEPTH_LIMIT + 2; i++) begin
         add_byte(i % 2 ? jaes_pkg::CH_LBRACE : jaes_pkg::CH_LBRACK);
      end
      repeat (DEPTH_LIMIT) add_byte(jaes_pkg::CH_RBRACE);
      append_text(",x]");
      send_message();
      append_text("[y]");
      send_message();
      wait_idle();
      steady = 1'b0;
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering a comma-heavy message, so the block fills and stalls its input.
   task automatic test_backpressure();
      stall_request = 1'b1;
      add_byte(jaes_pkg::CH_LBRACK);
      repeat (20) begin
         add_byte(word_char());
         add_byte(jaes_pkg::CH_COMMA);
      end
      append_text("8]");
      send_message();
      wait_idle();
   endtask

   task automatic test_random_messages();
      int unsigned first;
      first = bytes_sent;
      while (bytes_sent - first < RANDOM_ITEMS) begin
         build_random_message();
         send_message();
      end
      wait_idle();
   endtask

   // ------------------------------------------------------------------------
   // Receiver side and checking
   // ------------------------------------------------------------------------

   // The receiver takes reports at random, except during a requested
   // hold-off, which it counts down itself, and while steady is set.
   initial begin : report_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            stall_left    = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Values sampled at the edge are those from before it, so a report is
   // taken exactly when the handshake completes.
   always @(posedge clock) begin : report_check
      split_report_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $error("report with nothing expected: start %0d length %0d",
                   rsp_elem_start, rsp_elem_length);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            check_field("elem_start", want.elem_start, rsp_elem_start);
            check_field("elem_length", want.elem_length, rsp_elem_length);
            check_field("has_element", 16'(want.has_element), 16'(rsp_has_element));
            check_field("array_closed", 16'(want.array_closed),
                        16'(rsp_array_closed));
            check_field("depth_overflow", 16'(want.depth_overflow),
                        16'(rsp_depth_overflow));
            check_field("message_done", 16'(want.message_done),
                        16'(rsp_message_done));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence and end of run
   // ------------------------------------------------------------------------

   initial begin
      rearm_splitter();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_forms();
      test_depth_overflow();
      test_backpressure();
      test_random_messages();

      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // A hung handshake ends the run here.
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("== FAIL ==");
      $finish;
   end

endmodule
